// ===== rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared codes, types and fixed widths of the scaled playback clock.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  // Fixed field widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SCALE_W    = 32;  // speed, signed Q16.16
  localparam int unsigned SCALE_FRAC = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_PLAY_FROM  = 3'd1,
    OP_STOP       = 3'd2,
    OP_STOP_NEXT  = 3'd3,
    OP_STOP_AFTER = 3'd4,
    OP_REBASE     = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_REAL_TIME = 3'd0,
    CFG_TIME_SCALE    = 3'd1,
    CFG_RANGE_ENABLE  = 3'd2,
    CFG_RANGE_LOW     = 3'd3,
    CFG_RANGE_HIGH    = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_END_ARM,
    ST_ELAPSED,
    ST_DELTA,
    ST_MUL,
    ST_POS,
    ST_RNG_CMP,
    ST_RNG_SPAN,
    ST_RNG_DIV,
    ST_RNG_ADD,
    ST_END_SUM,
    ST_END_CMP,
    ST_END_BACK,
    ST_END_MARGIN,
    ST_RB_DIFF,
    ST_RB_START,
    ST_RB_END,
    ST_DONE
  } state_e;

  // Mode of the bit-serial adder
  typedef struct packed {
    logic sub;  // a - b instead of a + b
    logic sat;  // clamp to the time range on overflow
  } alu_mode_t;

endpackage

`default_nettype wire

// ===== rtl/spc_if.sv =====
// ----------------------------------------------------------------------------
// spc_if
// Valid/ready channels of the scaled playback clock: commands, results and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_cmd_if #(
  parameter int unsigned TIME_WIDTH = 48
);
  import spc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [TIME_WIDTH-1:0]   real_time;
  logic [TIME_WIDTH-1:0]   sim_time;
  logic [TIME_WIDTH-1:0]   amount;
  logic                    with_callback;

  modport source (output valid, op, real_time, sim_time, amount, with_callback,
                  input  ready);
  modport sink   (input  valid, op, real_time, sim_time, amount, with_callback,
                  output ready);
endinterface

interface spc_rsp_if #(
  parameter int unsigned TIME_WIDTH = 48
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] scaled_time;
  logic                  playing;
  logic                  apply_strobe;
  logic                  stopped_now;
  logic                  callback_due;

  modport source (output valid, scaled_time, playing, apply_strobe, stopped_now,
                         callback_due,
                  input  ready);
  modport sink   (input  valid, scaled_time, playing, apply_strobe, stopped_now,
                         callback_due,
                  output ready);
endinterface

interface spc_cfg_if #(
  parameter int unsigned TIME_WIDTH = 48
);
  import spc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [TIME_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/scaled_playback_clock_unit.sv =====
// ----------------------------------------------------------------------------
// scaled_playback_clock_unit
// Playback clock that advances a position by elapsed time times a signed
// speed, with loop range, timed stop and clock rebase.
// ----------------------------------------------------------------------------
// One request is handled at a time. Play from, stop, stop next tick, stop
// after and unused codes go straight from accept to result. Add and subtract
// steps run through one bit-serial adder, and a multiply or modulo steps one
// bit a cycle. A rebase runs the difference, start and end steps. A tick
// takes from 0 steps (not playing, no pending end) up to 13 (pending end,
// loop range and a reached end time). A plain running tick takes 4 steps
// (elapsed, delta, multiply, add). The result register lets the next request
// be accepted while a result waits to be taken. Registers may only be
// written while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_playback_clock_unit #(
  parameter int unsigned TIME_WIDTH = 48,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spc_cfg_if.sink      cfg_i,
  spc_cmd_if.sink      cmd_i,
  spc_rsp_if.source    rsp_o
);
  import spc_pkg::*;

  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned CNT_W = $clog2(TW);
  localparam int unsigned PW    = SCALE_W + TW;   // full product width
  localparam logic [TW-1:0] TMAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic [TW-1:0] TMIN = {1'b1, {(TW-1){1'b0}}};
  // 1 ms in time LSBs, rounded to nearest
  localparam int unsigned   MARGIN_LSB = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic [TW-1:0] END_MARGIN = TW'(MARGIN_LSB);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  // configuration
  logic               use_real_q, use_real_d;
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic               rng_en_q, rng_en_d;
  logic [TW-1:0]      rng_low_q, rng_low_d;
  logic [TW-1:0]      rng_high_q, rng_high_d;

  // playback state
  logic [TW-1:0] start_time_q, start_time_d;
  logic          start_set_q, start_set_d;
  logic [TW-1:0] last_el_q, last_el_d;
  logic [TW-1:0] pos_q, pos_d;
  logic [TW-1:0] end_time_q, end_time_d;
  logic          end_active_q, end_active_d;
  logic          end_pending_q, end_pending_d;
  logic          running_q, running_d;
  logic          stop_next_q, stop_next_d;
  logic          cb_armed_q, cb_armed_d;

  // sequencer
  state_e        state_q, state_d;
  logic          busy_q, busy_d;      // operands loaded, bits shifting
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic          is_tick_q, is_tick_d;
  logic          strobe_q, strobe_d;

  // serial datapath (no reset)
  logic [TW-1:0]      a_q, a_d;       // operand a / multiplier / dividend
  logic [TW-1:0]      b_q, b_d;       // operand b
  logic [TW-1:0]      r_q, r_d;       // sum bits, entered at the top
  logic               c_q, c_d;       // carry
  alu_mode_t          mode_q, mode_d;
  logic [TW-1:0]      tin_q, tin_d;   // tick time or rebase new clock
  logic [TW-1:0]      amt_q, amt_d;
  logic [TW-1:0]      tmp_q, tmp_d;   // intermediate / remainder
  logic [TW-1:0]      span_q, span_d;
  logic [SCALE_W-1:0] smag_q, smag_d;
  logic [SCALE_W-1:0] hi_q, hi_d;     // product upper part
  logic [TW-1:0]      lo_q, lo_d;     // product lower part
  logic               seen_q, seen_d; // a one bit has passed (serial negate)
  logic               dneg_q, dneg_d;
  logic               pneg_q, pneg_d;

  // result register
  logic          rsp_valid_q, rsp_valid_d;
  logic [TW-1:0] rsp_time_q, rsp_time_d;
  logic          rsp_play_q, rsp_play_d;
  logic          rsp_strobe_q, rsp_strobe_d;
  logic          rsp_stop_q, rsp_stop_d;
  logic          rsp_due_q, rsp_due_d;

  // --------------------------------------------------------------------------
  // Bit-serial adder, LSB first. On the last bit the overflow, exact sign and
  // saturated result are formed from the sign bits passing through.
  // --------------------------------------------------------------------------
  logic          bx0, s0, c_nx, ovf, neg_x, zero_x, last_bit;
  logic [TW-1:0] r_full, alu_res;

  assign bx0      = b_q[0] ^ mode_q.sub;
  assign s0       = a_q[0] ^ bx0 ^ c_q;
  assign c_nx     = (a_q[0] & bx0) | (a_q[0] & c_q) | (bx0 & c_q);
  assign r_full   = {s0, r_q[TW-1:1]};
  assign ovf      = (a_q[0] == bx0) && (s0 != a_q[0]);
  assign neg_x    = s0 ^ ovf;
  assign zero_x   = (r_full == '0) && !ovf;
  assign alu_res  = (mode_q.sat && ovf) ? (a_q[0] ? TMIN : TMAX) : r_full;
  assign last_bit = busy_q && (cnt_q == CNT_W'(TW - 1));

  // Shift-add multiplier: |scale| times |delta|, delta bits negated on the fly
  logic            mbit;
  logic [SCALE_W:0] madd;
  logic [PW-1:0]   prod;
  logic            psat;
  logic [TW-1:0]   pmag;

  assign mbit = a_q[0] ^ (dneg_q & seen_q);
  assign madd = {1'b0, hi_q} + (mbit ? {1'b0, smag_q} : {(SCALE_W+1){1'b0}});
  assign prod = {hi_q, lo_q};
  // truncated product above the time range saturates
  assign psat = |prod[PW-1:TW+SCALE_FRAC-1];
  assign pmag = {1'b0, prod[TW+SCALE_FRAC-2:SCALE_FRAC]};

  // Restoring modulo, one dividend bit per cycle, remainder in tmp_q
  logic [TW:0] dt, dsub;
  logic        dge;

  assign dt   = {tmp_q, a_q[TW-1]};
  assign dsub = dt - {1'b0, span_q};
  assign dge  = dt >= {1'b0, span_q};

  // Operand selection for the step about to load
  logic [TW-1:0] ld_a, ld_b;
  alu_mode_t     ld_mode;

  always_comb begin
    ld_a    = tmp_q;
    ld_b    = '0;
    ld_mode = '{sub: 1'b0, sat: 1'b1};
    unique case (state_q)
      ST_END_ARM: begin
        ld_a = tin_q;
        ld_b = end_time_q;
      end
      ST_ELAPSED: begin
        ld_a    = tin_q;
        ld_b    = start_set_q ? start_time_q : tin_q;
        ld_mode = '{sub: 1'b1, sat: 1'b1};
      end
      ST_DELTA: begin
        ld_b    = last_el_q;
        ld_mode = '{sub: 1'b1, sat: 1'b1};
      end
      ST_POS: begin
        ld_a    = pos_q;
        ld_b    = psat ? (pneg_q ? TMIN : TMAX) : pmag;
        ld_mode = '{sub: pneg_q && !psat, sat: 1'b1};
      end
      ST_RNG_CMP: begin
        ld_a    = pos_q;
        ld_b    = rng_low_q;
        ld_mode = '{sub: 1'b1, sat: 1'b0};
      end
      ST_RNG_SPAN: begin
        ld_a    = rng_high_q;
        ld_b    = rng_low_q;
        ld_mode = '{sub: 1'b1, sat: 1'b0};
      end
      ST_RNG_ADD: begin
        ld_a    = rng_low_q;
        ld_b    = tmp_q;
        ld_mode = '{sub: 1'b0, sat: 1'b0};
      end
      ST_END_SUM: begin
        ld_a = start_time_q;
        ld_b = pos_q;
      end
      ST_END_CMP: begin
        ld_b    = end_time_q;
        ld_mode = '{sub: 1'b1, sat: 1'b0};
      end
      ST_END_BACK: begin
        ld_a    = end_time_q;
        ld_b    = start_time_q;
        ld_mode = '{sub: 1'b1, sat: 1'b1};
      end
      ST_END_MARGIN: begin
        ld_b    = END_MARGIN;
        ld_mode = '{sub: 1'b1, sat: 1'b1};
      end
      ST_RB_DIFF: begin
        ld_a    = tin_q;
        ld_b    = amt_q;
        ld_mode = '{sub: 1'b1, sat: 1'b1};
      end
      ST_RB_START: begin
        ld_a = start_time_q;
        ld_b = tmp_q;
      end
      ST_RB_END: begin
        ld_a = end_time_q;
        ld_b = tmp_q;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Next state and handshakes
  // --------------------------------------------------------------------------
  logic   rsp_free, cmd_fire, stop_fire;
  state_e end_chk_st;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign stop_fire   = is_tick_q && stop_next_q;
  assign end_chk_st  = end_active_q ? ST_END_SUM : ST_DONE;

  always_comb begin
    use_real_d    = use_real_q;
    scale_d       = scale_q;
    rng_en_d      = rng_en_q;
    rng_low_d     = rng_low_q;
    rng_high_d    = rng_high_q;
    start_time_d  = start_time_q;
    start_set_d   = start_set_q;
    last_el_d     = last_el_q;
    pos_d         = pos_q;
    end_time_d    = end_time_q;
    end_active_d  = end_active_q;
    end_pending_d = end_pending_q;
    running_d     = running_q;
    stop_next_d   = stop_next_q;
    cb_armed_d    = cb_armed_q;
    state_d       = state_q;
    busy_d        = busy_q;
    cnt_d         = cnt_q;
    is_tick_d     = is_tick_q;
    strobe_d      = strobe_q;
    a_d           = a_q;
    b_d           = b_q;
    r_d           = r_q;
    c_d           = c_q;
    mode_d        = mode_q;
    tin_d         = tin_q;
    amt_d         = amt_q;
    tmp_d         = tmp_q;
    span_d        = span_q;
    smag_d        = smag_q;
    hi_d          = hi_q;
    lo_d          = lo_q;
    seen_d        = seen_q;
    dneg_d        = dneg_q;
    pneg_d        = pneg_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    rsp_time_d    = rsp_time_q;
    rsp_play_d    = rsp_play_q;
    rsp_strobe_d  = rsp_strobe_q;
    rsp_stop_d    = rsp_stop_q;
    rsp_due_d     = rsp_due_q;

    // register writes: the user must write only while idle; the block does not enforce it
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_USE_REAL_TIME: use_real_d = cfg_i.data[0];
        CFG_TIME_SCALE:    scale_d    = cfg_i.data[SCALE_W-1:0];
        CFG_RANGE_ENABLE:  rng_en_d   = cfg_i.data[0];
        CFG_RANGE_LOW:     rng_low_d  = cfg_i.data;
        CFG_RANGE_HIGH:    rng_high_d = cfg_i.data;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          is_tick_d = (op_e'(cmd_i.op) == OP_TICK);
          strobe_d  = (op_e'(cmd_i.op) == OP_TICK) && running_q;
          tin_d     = ((op_e'(cmd_i.op) == OP_TICK) && use_real_q) ?
                      cmd_i.real_time : cmd_i.sim_time;
          amt_d     = cmd_i.amount;
          busy_d    = 1'b0;
          state_d   = ST_DONE;
          unique case (op_e'(cmd_i.op))
            OP_TICK: begin
              if (end_pending_q)  state_d = ST_END_ARM;
              else if (running_q) state_d = ST_ELAPSED;
            end
            OP_PLAY_FROM: begin
              start_set_d   = 1'b0;
              end_active_d  = 1'b0;
              end_pending_d = 1'b0;
              running_d     = 1'b1;
              last_el_d     = '0;
              pos_d         = cmd_i.amount;
              cb_armed_d    = 1'b0;
            end
            OP_STOP:      running_d   = 1'b0;
            OP_STOP_NEXT: stop_next_d = 1'b1;
            OP_STOP_AFTER: begin
              end_active_d = 1'b0;
              // positive delay arms an end time on the next tick
              if (!cmd_i.amount[TW-1] && (cmd_i.amount != '0)) begin
                end_time_d    = cmd_i.amount;
                end_pending_d = 1'b1;
              end else begin
                end_pending_d = 1'b0;
              end
              if (cmd_i.with_callback) cb_armed_d = 1'b1;
            end
            OP_REBASE: state_d = ST_RB_DIFF;
            default: ;
          endcase
        end
      end

      ST_MUL: begin
        if (!busy_q) begin
          a_d    = tmp_q;
          dneg_d = tmp_q[TW-1];
          pneg_d = tmp_q[TW-1] ^ scale_q[SCALE_W-1];
          smag_d = scale_q[SCALE_W-1] ? (~scale_q + SCALE_W'(1)) : scale_q;
          hi_d   = '0;
          seen_d = 1'b0;
          cnt_d  = '0;
          busy_d = 1'b1;
        end else begin
          hi_d   = madd[SCALE_W:1];
          lo_d   = {madd[0], lo_q[TW-1:1]};
          a_d    = {1'b0, a_q[TW-1:1]};
          seen_d = seen_q | a_q[0];
          cnt_d  = cnt_q + CNT_W'(1);
          if (last_bit) begin
            busy_d  = 1'b0;
            state_d = ST_POS;
          end
        end
      end

      ST_RNG_DIV: begin
        if (!busy_q) begin
          a_d    = tmp_q;
          tmp_d  = '0;
          cnt_d  = '0;
          busy_d = 1'b1;
        end else begin
          tmp_d = dge ? dsub[TW-1:0] : dt[TW-1:0];
          a_d   = {a_q[TW-2:0], 1'b0};
          cnt_d = cnt_q + CNT_W'(1);
          if (last_bit) begin
            busy_d  = 1'b0;
            state_d = ST_RNG_ADD;
          end
        end
      end

      ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_time_d   = pos_q;
          rsp_play_d   = running_q && !stop_fire;
          rsp_strobe_d = strobe_q;
          rsp_stop_d   = stop_fire;
          rsp_due_d    = stop_fire && cb_armed_q;
          if (stop_fire) begin
            running_d   = 1'b0;
            stop_next_d = 1'b0;
            cb_armed_d  = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      // all remaining states are one pass of the serial adder
      default: begin
        if (!busy_q) begin
          a_d    = ld_a;
          b_d    = ld_b;
          mode_d = ld_mode;
          c_d    = ld_mode.sub;
          cnt_d  = '0;
          busy_d = 1'b1;
          // first running tick latches the start time
          if ((state_q == ST_ELAPSED) && !start_set_q) begin
            start_time_d = tin_q;
            start_set_d  = 1'b1;
          end
        end else begin
          a_d   = {1'b0, a_q[TW-1:1]};
          b_d   = {1'b0, b_q[TW-1:1]};
          r_d   = r_full;
          c_d   = c_nx;
          cnt_d = cnt_q + CNT_W'(1);
          if (last_bit) begin
            busy_d = 1'b0;
            unique case (state_q)
              ST_END_ARM: begin
                end_time_d    = alu_res;
                end_active_d  = 1'b1;
                end_pending_d = 1'b0;
                state_d       = running_q ? ST_ELAPSED : ST_DONE;
              end
              ST_ELAPSED: begin
                tmp_d   = alu_res;
                state_d = ST_DELTA;
              end
              ST_DELTA: begin
                last_el_d = tmp_q;
                tmp_d     = alu_res;
                state_d   = ST_MUL;
              end
              ST_POS: begin
                pos_d   = alu_res;
                state_d = rng_en_q ? ST_RNG_CMP : end_chk_st;
              end
              ST_RNG_CMP: begin
                // below the range: clamp to its floor
                if (neg_x) begin
                  pos_d = rng_low_q;
                  tmp_d = '0;
                end else begin
                  tmp_d = r_full;
                end
                state_d = ST_RNG_SPAN;
              end
              ST_RNG_SPAN: begin
                span_d = r_full;
                // empty or inverted range holds at the floor
                if (neg_x || zero_x) begin
                  pos_d   = rng_low_q;
                  state_d = end_chk_st;
                end else begin
                  state_d = ST_RNG_DIV;
                end
              end
              ST_RNG_ADD: begin
                pos_d   = alu_res;
                state_d = end_chk_st;
              end
              ST_END_SUM: begin
                tmp_d   = alu_res;
                state_d = ST_END_CMP;
              end
              ST_END_CMP: begin
                state_d = neg_x ? ST_DONE : ST_END_BACK;
              end
              ST_END_BACK: begin
                tmp_d   = alu_res;
                state_d = ST_END_MARGIN;
              end
              ST_END_MARGIN: begin
                pos_d       = alu_res;
                stop_next_d = 1'b1;
                state_d     = ST_DONE;
              end
              ST_RB_DIFF: begin
                tmp_d   = alu_res;
                state_d = ST_RB_START;
              end
              ST_RB_START: begin
                if (start_set_q) start_time_d = alu_res;
                state_d = ST_RB_END;
              end
              ST_RB_END: begin
                if (end_active_q) end_time_d = alu_res;
                state_d = ST_DONE;
              end
              default: state_d = ST_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Flops
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_real_q    <= 1'b0;
      scale_q       <= SCALE_W'(1 << SCALE_FRAC);
      rng_en_q      <= 1'b0;
      rng_low_q     <= '0;
      rng_high_q    <= '0;
      start_time_q  <= '0;
      start_set_q   <= 1'b0;
      last_el_q     <= '0;
      pos_q         <= '0;
      end_time_q    <= '0;
      end_active_q  <= 1'b0;
      end_pending_q <= 1'b0;
      running_q     <= 1'b0;
      stop_next_q   <= 1'b0;
      cb_armed_q    <= 1'b0;
      busy_q        <= 1'b0;
      cnt_q         <= '0;
      is_tick_q     <= 1'b0;
      strobe_q      <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      use_real_q    <= use_real_d;
      scale_q       <= scale_d;
      rng_en_q      <= rng_en_d;
      rng_low_q     <= rng_low_d;
      rng_high_q    <= rng_high_d;
      start_time_q  <= start_time_d;
      start_set_q   <= start_set_d;
      last_el_q     <= last_el_d;
      pos_q         <= pos_d;
      end_time_q    <= end_time_d;
      end_active_q  <= end_active_d;
      end_pending_q <= end_pending_d;
      running_q     <= running_d;
      stop_next_q   <= stop_next_d;
      cb_armed_q    <= cb_armed_d;
      busy_q        <= busy_d;
      cnt_q         <= cnt_d;
      is_tick_q     <= is_tick_d;
      strobe_q      <= strobe_d;
      rsp_valid_q   <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    r_q          <= r_d;
    c_q          <= c_d;
    mode_q       <= mode_d;
    tin_q        <= tin_d;
    amt_q        <= amt_d;
    tmp_q        <= tmp_d;
    span_q       <= span_d;
    smag_q       <= smag_d;
    hi_q         <= hi_d;
    lo_q         <= lo_d;
    seen_q       <= seen_d;
    dneg_q       <= dneg_d;
    pneg_q       <= pneg_d;
    rsp_time_q   <= rsp_time_d;
    rsp_play_q   <= rsp_play_d;
    rsp_strobe_q <= rsp_strobe_d;
    rsp_stop_q   <= rsp_stop_d;
    rsp_due_q    <= rsp_due_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.scaled_time  = rsp_time_q;
  assign rsp_o.playing      = rsp_play_q;
  assign rsp_o.apply_strobe = rsp_strobe_q;
  assign rsp_o.stopped_now  = rsp_stop_q;
  assign rsp_o.callback_due = rsp_due_q;

endmodule

`default_nettype wire

// ===== rtl/spc_checker.sv =====
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks of the scaled playback clock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_checker #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cmd_valid_i,
  input logic                  cmd_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic [TIME_WIDTH-1:0] rsp_time_i,
  input logic                  rsp_playing_i,
  input logic                  rsp_strobe_i,
  input logic                  rsp_stopped_i,
  input logic                  rsp_due_i
);

  // a stalled result keeps its position
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_time_i))
    else $error("stalled result changed");

  // one request in flight: no accept right after an accept
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("request accepted while busy");

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_stopped_i |-> !rsp_playing_i)
    else $error("still playing after a stop");

  a_due_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_due_i |-> rsp_stopped_i)
    else $error("callback without a stop");

  // a strobe means the clock ran on this tick
  a_strobe_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_strobe_i && !rsp_stopped_i |-> rsp_playing_i)
    else $error("strobe while not playing");

endmodule

bind scaled_playback_clock_unit spc_checker #(
  .TIME_WIDTH (TIME_WIDTH)
) u_spc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_time_i    (rsp_o.scaled_time),
  .rsp_playing_i (rsp_o.playing),
  .rsp_strobe_i  (rsp_o.apply_strobe),
  .rsp_stopped_i (rsp_o.stopped_now),
  .rsp_due_i     (rsp_o.callback_due)
);

`default_nettype wire

// ===== test/spc_clock_checker.sv =====
// ----------------------------------------------------------------------------
// spc_clock_checker
// Watches the register, request and result channels of the playback clock,
// keeps its own model of the clock state and compares every result with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_clock_checker #(
  parameter int unsigned TIME_WIDTH = 48,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spc_cfg_if          cfg_i,
  spc_cmd_if          cmd_i,
  spc_rsp_if          rsp_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);
  import spc_pkg::*;

  localparam longint TMAX = (longint'(1) <<< (TIME_WIDTH - 1)) - 1;
  localparam longint TMIN = -TMAX - 1;
  // 1 ms, rounded to the nearest LSB
  localparam longint STOP_MARGIN = ((longint'(1) <<< FRAC_BITS) + 500) / 1000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] scaled_time;
    logic                  playing;
    logic                  apply_strobe;
    logic                  stopped_now;
    logic                  callback_due;
  } status_t;

  // register copies
  bit     real_sel;
  longint speed;
  bit     range_on;
  longint range_lo;
  longint range_hi;

  // clock state
  longint start_time;
  bit     start_set;
  longint last_elapsed;
  longint position;
  longint end_time;
  bit     end_active;
  bit     end_pending;
  bit     running;
  bit     stop_next;
  bit     cb_armed;

  status_t     status_q[$];
  int unsigned fault_n;
  int unsigned result_n;

  function automatic longint to_time(logic [TIME_WIDTH-1:0] w);
    longint v;
    v = $signed(w);
    return v;
  endfunction

  function automatic longint clamp_time(longint x);
    if (x > TMAX) return TMAX;
    if (x < TMIN) return TMIN;
    return x;
  endfunction

  // operands stay within the time range, so 64-bit sums are exact
  function automatic longint sat_add(longint a, longint b);
    return clamp_time(a + b);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    return clamp_time(a - b);
  endfunction

  // speed * delta, truncated toward zero, then saturated
  function automatic longint scale_mul(longint s, longint d);
    logic [127:0] prod;
    logic [63:0]  ms;
    logic [63:0]  md;
    bit           neg;
    neg  = (s < 0) != (d < 0);
    ms   = (s < 0) ? -s : s;
    md   = (d < 0) ? -d : d;
    prod = {64'd0, ms} * {64'd0, md};
    prod = prod >> SCALE_FRAC;
    if (prod > 128'(TMAX)) return neg ? TMIN : TMAX;
    return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  function automatic status_t clock_step(logic [OP_W-1:0] op,
                                         logic [TIME_WIDTH-1:0] rt_w,
                                         logic [TIME_WIDTH-1:0] st_w,
                                         logic [TIME_WIDTH-1:0] amt_w,
                                         logic with_cb);
    longint  t;
    longint  st;
    longint  amt;
    longint  now_el;
    longint  delta;
    longint  diff;
    status_t res;
    res = '0;
    st  = to_time(st_w);
    amt = to_time(amt_w);
    case (op)
      OP_TICK: begin
        t = real_sel ? to_time(rt_w) : st;
        if (end_pending) begin
          end_time    = sat_add(t, end_time);
          end_active  = 1'b1;
          end_pending = 1'b0;
        end
        if (running) begin
          if (!start_set) begin
            start_time = t;
            start_set  = 1'b1;
          end
          now_el       = sat_sub(t, start_time);
          delta        = sat_sub(now_el, last_elapsed);
          last_elapsed = now_el;
          position     = sat_add(position, scale_mul(speed, delta));
          if (range_on) begin
            if (position < range_lo) position = range_lo;
            // empty or inverted range pins the time at its low end
            if (range_hi <= range_lo) position = range_lo;
            else position = range_lo + (position - range_lo) % (range_hi - range_lo);
          end
          if (end_active && sat_add(start_time, position) >= end_time) begin
            position  = sat_sub(sat_sub(end_time, start_time), STOP_MARGIN);
            stop_next = 1'b1;
          end
          res.apply_strobe = 1'b1;
        end
        if (stop_next) begin
          res.callback_due = cb_armed;
          res.stopped_now  = 1'b1;
          cb_armed         = 1'b0;
          running          = 1'b0;
          stop_next        = 1'b0;
        end
      end
      OP_PLAY_FROM: begin
        start_set    = 1'b0;
        end_active   = 1'b0;
        end_pending  = 1'b0;
        running      = 1'b1;
        last_elapsed = 0;
        position     = amt;
        cb_armed     = 1'b0;
      end
      OP_STOP:      running = 1'b0;
      OP_STOP_NEXT: stop_next = 1'b1;
      OP_STOP_AFTER: begin
        end_active = 1'b0;
        if (amt > 0) begin
          end_time    = amt;
          end_pending = 1'b1;
        end else begin
          end_pending = 1'b0;
        end
        if (with_cb) cb_armed = 1'b1;
      end
      OP_REBASE: begin
        diff = sat_sub(st, amt);
        if (start_set) start_time = sat_add(start_time, diff);
        if (end_active) end_time = sat_add(end_time, diff);
      end
      default: ;
    endcase
    res.scaled_time = position[TIME_WIDTH-1:0];
    res.playing     = running;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t got;
    status_t want;
    if (!rst_ni) begin
      real_sel      = 1'b0;
      speed         = longint'(1) <<< SCALE_FRAC;
      range_on      = 1'b0;
      range_lo      = 0;
      range_hi      = 0;
      start_time    = 0;
      start_set     = 1'b0;
      last_elapsed  = 0;
      position      = 0;
      end_time      = 0;
      end_active    = 1'b0;
      end_pending   = 1'b0;
      running       = 1'b0;
      stop_next     = 1'b0;
      cb_armed      = 1'b0;
      fault_n       = 0;
      result_n      = 0;
      status_q.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_USE_REAL_TIME: real_sel = cfg_i.data[0];
          CFG_TIME_SCALE:    speed    = $signed(cfg_i.data[SCALE_W-1:0]);
          CFG_RANGE_ENABLE:  range_on = cfg_i.data[0];
          CFG_RANGE_LOW:     range_lo = to_time(cfg_i.data);
          CFG_RANGE_HIGH:    range_hi = to_time(cfg_i.data);
          default: ;
        endcase
      end
      // results first: one taken at the same edge as a request is older
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.scaled_time, rsp_i.playing, rsp_i.apply_strobe,
               rsp_i.stopped_now, rsp_i.callback_due};
        if (status_q.size() == 0) begin
          fault_n++;
          if (fault_n <= REPORT_MAX)
            $display("%0t: result %0d arrived with no request waiting", $realtime,
                     result_n);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            fault_n++;
            if (fault_n <= REPORT_MAX) begin
              $write("%0t: result %0d mismatch: exp time %h play %b strobe %b stop %b cb %b",
                     $realtime, result_n, want.scaled_time, want.playing,
                     want.apply_strobe, want.stopped_now, want.callback_due);
              $display(", got time %h play %b strobe %b stop %b cb %b",
                       got.scaled_time, got.playing, got.apply_strobe,
                       got.stopped_now, got.callback_due);
            end
          end
        end
        result_n++;
      end
      if (cmd_i.valid && cmd_i.ready)
        status_q.push_back(clock_step(cmd_i.op, cmd_i.real_time, cmd_i.sim_time,
                                      cmd_i.amount, cmd_i.with_callback));
      mismatches_o  <= fault_n;
      outstanding_o <= status_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the scaled playback clock with a directed opening and then phases of
// random play, tick, stop and rebase requests under changing registers, with
// random idling on both channels; the checker beside the block judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import spc_pkg::*;

  localparam int unsigned TIME_WIDTH = 48;
  localparam int unsigned FRAC_BITS  = 16;

  localparam longint TMAX = (longint'(1) <<< (TIME_WIDTH - 1)) - 1;
  localparam longint TMIN = -TMAX - 1;
  localparam longint SEC  = longint'(1) <<< FRAC_BITS;  // 1.0 s in Q32.16

  // opcodes the block must treat as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int unsigned IDLE_PCT        = 38;
  localparam int unsigned NUM_PHASES      = 9;
  localparam int unsigned ITEMS_PER_PHASE = 215;
  localparam int unsigned CALM_PHASE      = 5;    // no idling on either side
  localparam int unsigned STALL_PHASE     = 2;    // long result hold-off
  localparam int unsigned DRAIN_PHASE     = 3;    // sender waits for all results
  localparam int unsigned RESULT_STALL    = 400;
  // With the worst tick, a full hold-off and idling on top, this limit
  // still leaves several times the slowest gap between two handshakes.
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned TAIL_CYCLES     = 700;
  localparam longint      CLOCK_BOUND     = longint'(1) <<< 44;

  logic clk_i;
  logic rst_ni;

  spc_cfg_if #(.TIME_WIDTH(TIME_WIDTH)) cfg ();
  spc_cmd_if #(.TIME_WIDTH(TIME_WIDTH)) cmd ();
  spc_rsp_if #(.TIME_WIDTH(TIME_WIDTH)) rsp ();

  int unsigned fail_n;
  int unsigned backlog_n;

  bit          idle_on = 1'b1;  // random idling on both sides
  int unsigned stall_reqs = 0;  // bumped to ask the receiver for a hold-off
  int unsigned quiet_cycles = 0;
  bit          rt_select;       // local copy of use_real_time
  longint      tick_clock;      // time base fed to ticks

  scaled_playback_clock_unit #(
    .TIME_WIDTH(TIME_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  spc_clock_checker #(
    .TIME_WIDTH(TIME_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_clock_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .rsp_i        (rsp),
    .mismatches_o (fail_n),
    .outstanding_o(backlog_n)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: random ready, or held low for a whole hold-off when asked.
  // The request counter is written with NBAs, so it is read race-free here.
  initial begin
    int unsigned hold_left;
    int unsigned seen;
    hold_left = 0;
    seen      = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_reqs != seen) begin
        seen      = stall_reqs;
        hold_left = RESULT_STALL;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: ends the run when no channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // full 48-bit random time, sign-extended
  function automatic longint rand_time();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return $signed(w[TIME_WIDTH-1:0]);
  endfunction

  // Offer one request and wait for its handshake. Called at a rising edge;
  // returns at the edge where the request was taken, valid still high, so
  // back-to-back requests never lower and raise valid in one step.
  task automatic send_request(logic [OP_W-1:0] op, longint rt, longint st,
                              longint amt, bit with_cb);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      cmd.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd.valid         <= 1'b1;
    cmd.op            <= op;
    cmd.real_time     <= rt[TIME_WIDTH-1:0];
    cmd.sim_time      <= st[TIME_WIDTH-1:0];
    cmd.amount        <= amt[TIME_WIDTH-1:0];
    cmd.with_callback <= with_cb;
    do @(posedge clk_i); while (!cmd.ready);
  endtask

  // Stop offering and wait until every result is back. One edge first so
  // that the checker has counted a request taken at the current edge.
  task automatic settle();
    cmd.valid <= 1'b0;
    @(posedge clk_i);
    while (backlog_n != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [TIME_WIDTH-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle. Unused data bits get noise.
  task automatic configure(bit use_rt, logic [SCALE_W-1:0] scale_word, bit ren,
                           longint lo, longint hi);
    logic [63:0] pad;
    settle();
    pad = {$urandom(), $urandom()};
    write_reg(CFG_USE_REAL_TIME, {pad[TIME_WIDTH-1:1], use_rt});
    write_reg(CFG_TIME_SCALE, {pad[TIME_WIDTH-1:SCALE_W], scale_word});
    pad = {$urandom(), $urandom()};
    write_reg(CFG_RANGE_ENABLE, {pad[TIME_WIDTH-1:1], ren});
    write_reg(CFG_RANGE_LOW, lo[TIME_WIDTH-1:0]);
    write_reg(CFG_RANGE_HIGH, hi[TIME_WIDTH-1:0]);
    rt_select = use_rt;
  endtask

  // Opening sequence, run with sim time selected, speed 1.0, range off.
  task automatic directed_requests();
    // stopped: a tick and spare codes only report the state
    send_request(OP_TICK, TMIN, TMAX, TMIN, 1'b1);
    send_request(OP_SPARE_6, -1, -1, -1, 1'b1);
    send_request(OP_SPARE_7, 0, 0, 0, 1'b0);
    send_request(OP_PLAY_FROM, rand_time(), rand_time(), 2 * SEC, 1'b0);
    // rebase before the first tick must not touch the unlatched start
    send_request(OP_REBASE, rand_time(), 7 * SEC, 3 * SEC, 1'b0);
    send_request(OP_TICK, rand_time(), 10 * SEC, rand_time(), 1'b0);
    send_request(OP_TICK, rand_time(), 11 * SEC, rand_time(), 1'b0);
    // end time armed with callback, overrun on the next tick
    send_request(OP_STOP_AFTER, rand_time(), rand_time(), SEC, 1'b1);
    send_request(OP_TICK, rand_time(), 11 * SEC + SEC / 2, rand_time(), 1'b0);
    send_request(OP_TICK, rand_time(), 12 * SEC, rand_time(), 1'b0);
    // saturation at the ends of the time range
    send_request(OP_PLAY_FROM, 0, 0, TMAX, 1'b0);
    send_request(OP_TICK, rand_time(), TMIN, rand_time(), 1'b0);
    send_request(OP_TICK, rand_time(), TMAX, rand_time(), 1'b0);
    // zero and negative delays cancel; the callback stays armed
    send_request(OP_STOP_AFTER, 0, 0, 0, 1'b0);
    send_request(OP_STOP_AFTER, 0, 0, TMIN, 1'b1);
    send_request(OP_REBASE, 0, TMAX, TMIN, 1'b0);
    send_request(OP_STOP_NEXT, rand_time(), rand_time(), rand_time(), 1'b0);
    send_request(OP_TICK, rand_time(), 0, rand_time(), 1'b0);
    // running backwards in time, then a rebase with an active end time
    send_request(OP_PLAY_FROM, 0, 0, TMIN, 1'b0);
    send_request(OP_TICK, rand_time(), 0, rand_time(), 1'b0);
    send_request(OP_STOP_AFTER, 0, 0, 2 * SEC, 1'b0);
    send_request(OP_TICK, rand_time(), -SEC, rand_time(), 1'b0);
    send_request(OP_REBASE, rand_time(), 10 * SEC, SEC, 1'b0);
    send_request(OP_STOP, rand_time(), rand_time(), rand_time(), 1'b1);
    // a pending stop takes effect even on a stopped tick
    send_request(OP_STOP_NEXT, rand_time(), rand_time(), rand_time(), 1'b1);
    send_request(OP_TICK, rand_time(), rand_time(), rand_time(), 1'b0);
  endtask

  // Mostly well-formed playback: ticks on a moving clock, play, timed stops,
  // rebases; the rest is noise over every field and every opcode.
  task automatic random_request();
    int unsigned pick;
    int unsigned sub;
    longint      step_t;
    longint      amt;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    if (pick < 55) begin
      if (sub < 3) step_t = -longint'($urandom_range(2 * SEC));
      else if (sub < 5) step_t = longint'($urandom()) * 64;
      else step_t = longint'($urandom_range(4 * SEC));
      tick_clock += step_t;
      if (tick_clock > CLOCK_BOUND || tick_clock < -CLOCK_BOUND) tick_clock = 0;
      if (rt_select)
        send_request(OP_TICK, tick_clock, rand_time(), rand_time(), 1'($urandom_range(1)));
      else
        send_request(OP_TICK, rand_time(), tick_clock, rand_time(), 1'($urandom_range(1)));
    end else if (pick < 65) begin
      if (sub < 90) amt = longint'($urandom_range(40 * SEC)) - 20 * SEC;
      else amt = rand_time();
      send_request(OP_PLAY_FROM, rand_time(), rand_time(), amt, 1'($urandom_range(1)));
    end else if (pick < 73) begin
      if (sub < 80) amt = longint'($urandom_range(3 * SEC, 1));
      else if (sub < 90) amt = -longint'($urandom_range(SEC));
      else amt = rand_time();
      send_request(OP_STOP_AFTER, rand_time(), rand_time(), amt, 1'($urandom_range(1)));
    end else if (pick < 77) begin
      send_request(OP_STOP_NEXT, rand_time(), rand_time(), rand_time(),
                   1'($urandom_range(1)));
    end else if (pick < 81) begin
      send_request(OP_STOP, rand_time(), rand_time(), rand_time(), 1'($urandom_range(1)));
    end else if (pick < 86) begin
      // sim clock jumps from its current value by up to 5 s either way
      step_t = longint'($urandom_range(10 * SEC)) - 5 * SEC;
      send_request(OP_REBASE, rand_time(), tick_clock + step_t, tick_clock,
                   1'($urandom_range(1)));
      if (!rt_select) tick_clock += step_t;
    end else begin
      send_request(OP_W'($urandom_range(7)), rand_time(), rand_time(), rand_time(),
                   1'($urandom_range(1)));
    end
  endtask

  initial begin
    longint lo;
    rst_ni            <= 1'b0;
    cmd.valid         <= 1'b0;
    cmd.op            <= OP_TICK;
    cmd.real_time     <= '0;
    cmd.sim_time      <= '0;
    cmd.amount        <= '0;
    cmd.with_callback <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= CFG_USE_REAL_TIME;
    cfg.data          <= '0;
    rt_select         = 1'b0;
    tick_clock        = longint'($urandom_range(100 * SEC));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: configure(1'b0, 32'd65536, 1'b0, 0, 0);
        // reverse play into a 10 s loop
        1: configure(1'b1, -32'sd65536, 1'b1, 0, 10 * SEC);
        // fastest forward speed, range off but at the extremes
        2: configure(1'b0, 32'h7fff_ffff, 1'b0, TMIN, TMAX);
        // most negative speed, loop over the whole time range
        3: configure(1'b1, 32'h8000_0000, 1'b1, TMIN, TMAX);
        // zero-width loop range
        4: configure(1'b0, 32'd32768, 1'b1, 5 * SEC, 5 * SEC);
        // inverted loop range
        5: configure(1'b1, 32'd131072, 1'b1, 10 * SEC, -10 * SEC);
        6: begin
          lo = longint'($urandom_range(20 * SEC)) - 10 * SEC;
          configure(1'b0, $urandom(), 1'b1, lo, lo + longint'($urandom_range(8 * SEC, 1)));
        end
        // frozen clock
        7: configure(1'b1, 32'd0, 1'b1, -3 * SEC, 2 * SEC);
        default: configure(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)),
                           rand_time(), rand_time());
      endcase
      idle_on <= (ph != CALM_PHASE);
      if (ph == 0) directed_requests();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender keeps offering while results are held back
        if (ph == STALL_PHASE && n == 40) stall_reqs <= stall_reqs + 1;
        if (ph == DRAIN_PHASE && n == 100) settle();
        random_request();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_n == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
